@@ rtl/sample_buffer_statistics_macros.svh @@
// ----------------------------------------------------------------------------
// Sample buffer statistics assertion macros
// Shared assertion helpers that use the enclosing module's clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_BUFFER_STATISTICS_MACROS_SVH
`define SAMPLE_BUFFER_STATISTICS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Sample buffer statistics package
// Opcodes, status codes, controller states and default sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbs_pkg;

	localparam int DEF_CAPACITY = 256;

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_SORT   = 3'd4;
	localparam logic [2:0] OP_STATS  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_INDEX = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef enum logic [11:0] {
		S_IDLE       = 12'b000000000001,
		S_READ       = 12'b000000000010,
		S_DEL        = 12'b000000000100,
		S_SORT_FIRST = 12'b000000001000,
		S_SORT_RUN   = 12'b000000010000,
		S_SORT_LAST  = 12'b000000100000,
		S_SUM        = 12'b000001000000,
		S_MUL        = 12'b000010000000,
		S_DIFF       = 12'b000100000000,
		S_MEAN       = 12'b001000000000,
		S_VAR        = 12'b010000000000,
		S_SD         = 12'b100000000000
	} state_t;

endpackage

@@ rtl/sbs_ram.sv @@
// ----------------------------------------------------------------------------
// Sample buffer statistics RAM
// Generic one-write one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/sbs_div.sv @@
// ----------------------------------------------------------------------------
// Sample buffer statistics divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbs_div #(
	parameter int DVD_W = 40,
	parameter int DVS_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? shifted - {1'b0, dvs_q} : shifted;
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[DVS_W-1:0];

endmodule

@@ rtl/sbs_sqrt.sv @@
// ----------------------------------------------------------------------------
// Sample buffer statistics square root
// Restoring integer square root producing one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbs_sqrt #(
	parameter int IN_W = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IN_W-1:0]     radicand,
	output logic                busy,
	output logic [IN_W/2-1:0]   root
);

	localparam int RW    = IN_W / 2;
	localparam int CNT_W = $clog2(RW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [IN_W-1:0]  x_q;
	logic [RW+1:0]    rem_q;
	logic [RW-1:0]    root_q;
	logic [RW+2:0]    shifted;
	logic [RW+2:0]    trial;
	logic             fits;

	assign shifted = {rem_q[RW:0], x_q[IN_W-1 -: 2]};
	assign trial   = (RW+3)'({root_q, 2'b01});
	assign fits    = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(RW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[IN_W-3:0], 2'b00};
			rem_q  <= (RW+2)'(fits ? shifted - trial : shifted);
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

@@ rtl/sample_buffer_statistics.sv @@
// ----------------------------------------------------------------------------
// Sample buffer statistics
// Ordered store of signed 8-bit samples in a RAM, with edit, sort and
// statistics commands.
//
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------
// command  | start, busy        | opcode, index, value
// result   | done (one cycle)   | status, read_value, count, minimum, maximum,
//          |                    | total, mean_q8, variance_q8, std_dev_q8,
//          |                    | median_x2
//
// Append, overwrite and rejected commands are answered from the idle state; read passes through S_READ.
// Delete shifts each later sample down one address through the single RAM write port.
// Sort runs bubble passes (S_SORT_FIRST, S_SORT_RUN, S_SORT_LAST) until a pass swaps nothing.
// Statistics sorts first when count is two or more, then sums the samples
// and multiplies, then runs three bit-serial divisions, started from S_DIFF,
// S_MEAN and S_VAR, the last one waiting on a bit-serial square root.
// Reset clears the count and controller; no RAM clearing pass is needed.
// The receiver cannot stall: done marks each result for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sample_buffer_statistics_macros.svh"

module sample_buffer_statistics
	import sbs_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         opcode,
	input  logic [7:0]         index,
	input  logic signed [7:0]  value,
	output logic               busy,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [7:0]  read_value,
	output logic [8:0]         count,
	output logic signed [7:0]  minimum,
	output logic signed [7:0]  maximum,
	output logic signed [15:0] total,
	output logic signed [15:0] mean_q8,
	output logic [21:0]        variance_q8,
	output logic [14:0]        std_dev_q8,
	output logic signed [8:0]  median_x2
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int IXW = (CW > 8) ? CW : 8;
	localparam int SW  = (CW + 8 > 17) ? CW + 8 : 17;
	localparam int S2W = CW + 14;
	localparam int DW  = 2 * CW + 14;
	localparam int QW  = DW + 8;
	localparam int NW  = 2 * CW;
	localparam int RW  = CW + 15;
	localparam logic signed [SW-1:0] TOT_MAX = SW'(32767);
	localparam logic signed [SW-1:0] TOT_MIN = -SW'(32768);

	state_t state_q, state_d;
	logic [CW-1:0]         count_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic signed [7:0]     rd_q;
	logic                  stat_vld_q;
	logic [CW-1:0]         j_q;
	logic signed [7:0]     carry_q;
	logic                  swapped_q;
	logic                  stats_q;
	logic signed [SW-1:0]  sum_q;
	logic [S2W-1:0]        sq_q;
	logic signed [7:0]     min_q, max_q, meda_q, medb_q;
	logic [DW-1:0]         p1_q, p2_q, d_q;
	logic [NW-1:0]         nn_q;
	logic signed [15:0]    mean_q;
	logic [21:0]           var_q;
	logic [14:0]           sd_q;

	logic                  acc, full, ix_ok, ix_more, j_more, del_more, lt, cnt_ge2;
	logic                  emit, cnt_inc, cnt_dec;
	logic [1:0]            emit_st;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic signed [7:0]     ram_wdata, ram_rdata;
	logic                  div_start, div_busy, sq_start, sq_busy;
	logic [QW-1:0]         div_dvd, div_quot;
	logic [NW-1:0]         div_dvs, div_rem;
	logic [RW-1:0]         sq_root;
	logic [SW-1:0]         abs_sum;
	logic signed [15:0]    sq_sample;
	logic signed [15:0]    tot_sat;

	assign acc      = start && (state_q == S_IDLE);
	assign full     = count_q == CW'(CAPACITY);
	assign ix_ok    = IXW'(index) < IXW'(count_q);
	assign ix_more  = ((IXW+1)'(index) + (IXW+1)'(1)) < (IXW+1)'(count_q);
	assign j_more   = ((CW+1)'(j_q) + (CW+1)'(1)) < (CW+1)'(count_q);
	assign del_more = ((CW+1)'(j_q) + (CW+1)'(2)) < (CW+1)'(count_q);
	assign lt       = ram_rdata < carry_q;
	assign cnt_ge2  = count_q >= CW'(2);
	assign abs_sum  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign sq_sample = ram_rdata * ram_rdata;

	sbs_ram #(
		.WIDTH(8),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sbs_div #(
		.DVD_W(QW),
		.DVS_W(NW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.busy      (div_busy),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	sbs_sqrt #(
		.IN_W(DW + 16)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({d_q, 16'h0000}),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_st   = ST_OK;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = AW'(j_q);
		ram_wdata = carry_q;
		ram_raddr = '0;
		div_start = 1'b0;
		div_dvd   = QW'({abs_sum, 8'h00});
		div_dvs   = NW'(count_q);
		sq_start  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (opcode)
						OP_APPEND: begin
							emit = 1'b1;
							if (full) begin
								emit_st = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = AW'(count_q);
								ram_wdata = value;
								cnt_inc   = 1'b1;
							end
						end
						OP_WRITE: begin
							emit = 1'b1;
							if (ix_ok) begin
								ram_we    = 1'b1;
								ram_waddr = AW'(index);
								ram_wdata = value;
							end else begin
								emit_st = ST_INDEX;
							end
						end
						OP_READ: begin
							ram_raddr = AW'(index);
							if (ix_ok) begin
								state_d = S_READ;
							end else begin
								emit    = 1'b1;
								emit_st = ST_INDEX;
							end
						end
						OP_DELETE: begin
							ram_raddr = AW'(index) + AW'(1);
							if (!ix_ok) begin
								emit    = 1'b1;
								emit_st = ST_INDEX;
							end else if (ix_more) begin
								state_d = S_DEL;
							end else begin
								cnt_dec = 1'b1;
								emit    = 1'b1;
							end
						end
						OP_SORT: begin
							if (cnt_ge2) begin
								state_d = S_SORT_FIRST;
							end else begin
								emit = 1'b1;
							end
						end
						OP_STATS: begin
							if (count_q == '0) begin
								emit    = 1'b1;
								emit_st = ST_EMPTY;
							end else if (cnt_ge2) begin
								state_d = S_SORT_FIRST;
							end else begin
								state_d = S_SUM;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_DEL: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(j_q);
				ram_wdata = ram_rdata;
				ram_raddr = AW'(j_q) + AW'(2);
				if (!del_more) begin
					cnt_dec = 1'b1;
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SORT_FIRST: begin
				ram_raddr = AW'(1);
				state_d   = S_SORT_RUN;
			end
			S_SORT_RUN: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(j_q - CW'(1));
				ram_wdata = lt ? ram_rdata : carry_q;
				ram_raddr = AW'(j_q) + AW'(1);
				if (!j_more) begin
					state_d = S_SORT_LAST;
				end
			end
			S_SORT_LAST: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(count_q - CW'(1));
				ram_wdata = carry_q;
				if (swapped_q) begin
					state_d = S_SORT_FIRST;
				end else if (stats_q) begin
					state_d = S_SUM;
				end else begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SUM: begin
				ram_raddr = AW'(j_q) + AW'(1);
				if (!j_more) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_DIFF;
			end
			S_DIFF: begin
				div_start = 1'b1;
				state_d   = S_MEAN;
			end
			S_MEAN: begin
				div_dvd = {d_q, 8'h00};
				div_dvs = nn_q;
				if (!div_busy) begin
					div_start = 1'b1;
					sq_start  = 1'b1;
					state_d   = S_VAR;
				end
			end
			S_VAR: begin
				div_dvd = QW'(sq_root);
				if (!div_busy && !sq_busy) begin
					div_start = 1'b1;
					state_d   = S_SD;
				end
			end
			S_SD: begin
				if (!div_busy) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q   <= emit_st;
			rd_q       <= (state_q == S_READ) ? ram_rdata : 8'sd0;
			stat_vld_q <= state_q == S_SD;
		end
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					swapped_q <= 1'b0;
					stats_q   <= opcode == OP_STATS;
					sum_q     <= '0;
					sq_q      <= '0;
					if (opcode == OP_DELETE) begin
						j_q <= CW'(index);
					end else begin
						j_q <= (state_d == S_SUM) ? CW'(0) : CW'(1);
					end
				end
			end
			S_DEL: begin
				j_q <= j_q + CW'(1);
			end
			S_SORT_FIRST: begin
				carry_q <= ram_rdata;
			end
			S_SORT_RUN: begin
				if (lt) begin
					swapped_q <= 1'b1;
				end else begin
					carry_q <= ram_rdata;
				end
				if (j_more) begin
					j_q <= j_q + CW'(1);
				end
			end
			S_SORT_LAST: begin
				swapped_q <= 1'b0;
				sum_q     <= '0;
				sq_q      <= '0;
				j_q       <= (state_d == S_SUM) ? CW'(0) : CW'(1);
			end
			S_SUM: begin
				sum_q <= sum_q + SW'(ram_rdata);
				sq_q  <= sq_q + S2W'(unsigned'(sq_sample));
				if (j_q == '0) begin
					min_q <= ram_rdata;
				end
				if (j_q == count_q - CW'(1)) begin
					max_q <= ram_rdata;
				end
				if (j_q == ((count_q - CW'(1)) >> 1)) begin
					meda_q <= ram_rdata;
				end
				if (j_q == (count_q >> 1)) begin
					medb_q <= ram_rdata;
				end
				if (j_more) begin
					j_q <= j_q + CW'(1);
				end
			end
			S_MUL: begin
				p1_q <= DW'(count_q) * DW'(sq_q);
				p2_q <= DW'(abs_sum) * DW'(abs_sum);
				nn_q <= NW'(count_q) * NW'(count_q);
			end
			S_DIFF: begin
				d_q <= (p1_q >= p2_q) ? p1_q - p2_q : '0;
			end
			S_MEAN: begin
				if (!div_busy) begin
					if (sum_q[SW-1]) begin
						mean_q <= 16'(-(div_quot + QW'(|div_rem)));
					end else begin
						mean_q <= 16'(div_quot);
					end
				end
			end
			S_VAR: begin
				if (!div_busy && !sq_busy) begin
					var_q <= 22'(div_quot);
				end
			end
			S_SD: begin
				if (!div_busy) begin
					sd_q <= 15'(div_quot);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (sum_q > TOT_MAX) begin
			tot_sat = 16'sd32767;
		end else if (sum_q < TOT_MIN) begin
			tot_sat = -16'sd32768;
		end else begin
			tot_sat = 16'(sum_q);
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = rd_q;
	assign count       = 9'(count_q);
	assign minimum     = stat_vld_q ? min_q : 8'sd0;
	assign maximum     = stat_vld_q ? max_q : 8'sd0;
	assign total       = stat_vld_q ? tot_sat : 16'sd0;
	assign mean_q8     = stat_vld_q ? mean_q : 16'sd0;
	assign variance_q8 = stat_vld_q ? var_q : 22'd0;
	assign std_dev_q8  = stat_vld_q ? sd_q : 15'd0;
	assign median_x2   = stat_vld_q ? (9'(meda_q) + 9'(medb_q)) : 9'sd0;

	`SBS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "Sample count exceeds capacity.")
	`SBS_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE, "Result issued while not idle.")
	`SBS_ASSERT_NXT(a_append_grows, acc && opcode == OP_APPEND && !full, count_q == $past(count_q) + CW'(1), "Append did not grow the count.")
	`SBS_ASSERT_IMP(a_units_idle, state_q == S_IDLE, !div_busy && !sq_busy, "Arithmetic unit busy while idle.")

endmodule

@@ test/sample_buffer_statistics_tb.sv @@
// ----------------------------------------------------------------------------
// Sample buffer statistics testbench
// Drives edit, read, sort and statistics commands into the sample store with
// random sender gaps, predicts every result from a private copy of the store
// and compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_buffer_statistics_tb;
	import sbs_pkg::*;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [7:0]  read_value;
		logic [8:0]         count;
		logic signed [7:0]  minimum;
		logic signed [7:0]  maximum;
		logic signed [15:0] total;
		logic signed [15:0] mean_q8;
		logic [21:0]        variance_q8;
		logic [14:0]        std_dev_q8;
		logic signed [8:0]  median_x2;
	} result_t;

	class stats_scoreboard;
		logic signed [7:0] samples [DEF_CAPACITY];
		int                n_samples = 0;
		result_t           pending [$];
		int                errors = 0;

		function void sort_samples();
			logic signed [7:0] key;
			int j;
			for (int i = 1; i < n_samples; i++) begin
				key = samples[i];
				j = i;
				while (j > 0 && samples[j - 1] > key) begin
					samples[j] = samples[j - 1];
					j--;
				end
				samples[j] = key;
			end
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned res = 0;
			longint unsigned b = 64'd1 << 62;
			while (b > x)
				b >>= 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function void note_command(logic [2:0] op, logic [7:0] idx, logic signed [7:0] val);
			result_t r;
			longint s, s2, d, n, q;
			r = '0;
			case (op)
				OP_APPEND: begin
					if (n_samples >= DEF_CAPACITY)
						r.status = ST_FULL;
					else
						samples[n_samples++] = val;
				end
				OP_WRITE: begin
					if (idx >= n_samples)
						r.status = ST_INDEX;
					else
						samples[idx] = val;
				end
				OP_DELETE: begin
					if (idx >= n_samples) begin
						r.status = ST_INDEX;
					end else begin
						for (int i = idx; i + 1 < n_samples; i++)
							samples[i] = samples[i + 1];
						n_samples--;
					end
				end
				OP_READ: begin
					if (idx >= n_samples)
						r.status = ST_INDEX;
					else
						r.read_value = samples[idx];
				end
				OP_SORT: sort_samples();
				OP_STATS: begin
					if (n_samples == 0) begin
						r.status = ST_EMPTY;
					end else begin
						sort_samples();
						n = n_samples;
						s = 0;
						s2 = 0;
						for (int i = 0; i < n_samples; i++) begin
							s += samples[i];
							s2 += longint'(samples[i]) * samples[i];
						end
						r.minimum = samples[0];
						r.maximum = samples[n_samples - 1];
						r.total = 16'((s > 32767) ? 32767 : (s < -32768) ? -32768 : s);
						q = (s * 256) / n;
						if ((s * 256) % n != 0 && s < 0)
							q -= 1;
						r.mean_q8 = 16'(q);
						d = n * s2 - s * s;
						if (d < 0)
							d = 0;
						r.variance_q8 = 22'((d * 256) / (n * n));
						r.std_dev_q8 = 15'(int_sqrt(d * 65536) / n);
						r.median_x2 = 9'(longint'(samples[(n_samples - 1) / 2])
							+ samples[n_samples / 2]);
					end
				end
				default: ;
			endcase
			r.count = 9'(n_samples);
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result transaction: %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("Result mismatch:\n  expected %p\n  actual   %p", want, got);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         opcode = OP_APPEND;
	logic [7:0]         index = '0;
	logic signed [7:0]  value = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic signed [7:0]  read_value;
	logic [8:0]         count;
	logic signed [7:0]  minimum;
	logic signed [7:0]  maximum;
	logic signed [15:0] total;
	logic signed [15:0] mean_q8;
	logic [21:0]        variance_q8;
	logic [14:0]        std_dev_q8;
	logic signed [8:0]  median_x2;

	stats_scoreboard sb = new();
	int              idle_pct = 0;

	sample_buffer_statistics uut (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode), .index(index),
		.value(value), .busy(busy), .done(done), .status(status),
		.read_value(read_value), .count(count), .minimum(minimum), .maximum(maximum),
		.total(total), .mean_q8(mean_q8), .variance_q8(variance_q8),
		.std_dev_q8(std_dev_q8), .median_x2(median_x2)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({status, read_value, count, minimum, maximum, total,
				mean_q8, variance_q8, std_dev_q8, median_x2});
	end

	task automatic issue(input logic [2:0] op, input logic [7:0] idx,
			input logic signed [7:0] val);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		start = 1'b1;
		opcode = op;
		index = idx;
		value = val;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(op, idx, val);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic random_command();
		int r;
		int c;
		logic [7:0] idx;
		c = sb.n_samples;
		r = $urandom_range(99);
		if ($urandom_range(99) < 80 && c > 0)
			idx = 8'($urandom_range(c - 1));
		else
			idx = 8'($urandom_range(255));
		if (c == 0 && r < 60)
			issue(OP_APPEND, idx, 8'($urandom_range(255)));
		else if (r < ((c < 48) ? 30 : 10))
			issue(OP_APPEND, idx, 8'($urandom_range(255)));
		else if (r < 45)
			issue(OP_WRITE, idx, 8'($urandom_range(255)));
		else if (r < 60)
			issue(OP_DELETE, idx, 8'($urandom_range(255)));
		else if (r < 80)
			issue(OP_READ, idx, 8'($urandom_range(255)));
		else if (r < 88)
			issue(OP_SORT, idx, 8'($urandom_range(255)));
		else
			issue(OP_STATS, idx, 8'($urandom_range(255)));
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		issue(OP_STATS, 8'd0, 8'sd0);
		issue(OP_SORT, 8'd0, 8'sd0);
		issue(OP_READ, 8'd0, 8'sd0);
		issue(OP_DELETE, 8'd0, 8'sd0);
		issue(OP_WRITE, 8'd0, 8'sd5);
		issue(OP_APPEND, 8'd0, -8'sd128);
		issue(OP_STATS, 8'd0, 8'sd0);
		issue(OP_APPEND, 8'd0, 8'sd127);
		issue(OP_APPEND, 8'd0, 8'sd0);
		issue(OP_APPEND, 8'd0, -8'sd1);
		issue(OP_READ, 8'd0, 8'sd0);
		issue(OP_READ, 8'd3, 8'sd0);
		issue(OP_READ, 8'd4, 8'sd0);
		issue(OP_WRITE, 8'd1, 8'sd127);
		issue(OP_WRITE, 8'd255, 8'sd1);
		issue(OP_STATS, 8'd0, 8'sd0);
		issue(OP_APPEND, 8'd0, 8'sd5);
		issue(OP_STATS, 8'd0, 8'sd0);
		issue(OP_DELETE, 8'd0, 8'sd0);
		issue(OP_DELETE, 8'd3, 8'sd0);
		issue(OP_DELETE, 8'd255, 8'sd0);
		issue(OP_APPEND, 8'd0, 8'sd100);
		issue(OP_SORT, 8'd0, 8'sd0);
		issue(OP_READ, 8'd3, 8'sd0);

		idle_pct = 34;
		repeat (480) random_command();
		idle_pct = 84;
		repeat (480) random_command();
		idle_pct = 0;
		while (sb.n_samples < DEF_CAPACITY)
			issue(OP_APPEND, 8'd0, 8'($urandom_range(255)));
		issue(OP_APPEND, 8'd0, 8'sd1);
		issue(OP_APPEND, 8'd0, -8'sd1);
		issue(OP_READ, 8'd255, 8'sd0);
		issue(OP_WRITE, 8'd255, -8'sd128);
		issue(OP_STATS, 8'd0, 8'sd0);
		issue(OP_READ, 8'd255, 8'sd0);
		issue(OP_WRITE, 8'd0, 8'sd127);
		issue(OP_SORT, 8'd0, 8'sd0);
		issue(OP_DELETE, 8'd255, 8'sd0);
		issue(OP_DELETE, 8'd0, 8'sd0);
		while (sb.n_samples > 30)
			issue(OP_DELETE, 8'($urandom_range(sb.n_samples - 1)), 8'sd0);
		repeat (200) random_command();

		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#50000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ sample_buffer_statistics.f @@
+incdir+rtl
rtl/sbs_pkg.sv
rtl/sbs_ram.sv
rtl/sbs_div.sv
rtl/sbs_sqrt.sv
rtl/sample_buffer_statistics.sv
test/sample_buffer_statistics_tb.sv
